### rtl/core/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; compiled first.
package bra_pkg;

  localparam int POOL_CELLS_DEF = 16;

  localparam int OPCODE_W = 1;
  localparam int COUNT_W  = 5;
  localparam int START_W  = 4;
  localparam int FIRST_W  = 4;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COUNT_W-1:0]  cell_count;
    logic [START_W-1:0]  start_cell;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [FIRST_W-1:0] first_cell;
    logic               pool_empty;
  } rsp_t;

endpackage

### rtl/core/bra_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is a parameter; no package dependency.
interface bra_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bitmap_run_allocator.sv
// First-fit contiguous run allocator over a busy bitmap.
// Allocate scans the cells in order for a free run of cell_count cells, then returns to
// the run's first cell and marks each cell busy, then finishes; free clears each cell.
// One request at a time: a new request is taken only in the idle state.
// A result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears the bitmap to all free and empties the output.
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int POOL_CELLS = POOL_CELLS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bra_stream_if.sink   req,
  bra_stream_if.source rsp
);

  localparam int IDX_W  = $clog2(POOL_CELLS);
  localparam int CNT_W  = $clog2(POOL_CELLS + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int POS_W  = COUNT_W + 1;
  localparam int FCMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int EXT_W  = FIRST_W + IDX_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_MARK   = 3'd2;
  localparam logic [2:0] ST_FREE   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state;
  logic [POOL_CELLS-1:0] busy_map;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      last;
  logic [CNT_W-1:0]      run;
  logic [CNT_W-1:0]      want;
  logic [POS_W-1:0]      pos;
  logic [COUNT_W-1:0]    rem;
  logic                  res_ok;
  logic [IDX_W-1:0]      res_first;
  logic                  out_valid;
  rsp_t                  out_data;

  logic                  in_fire;
  logic                  load_out;
  logic [CNT_W-1:0]      run_inc;
  logic [CNT_W-1:0]      first_calc;
  logic                  count_bad;
  logic                  pos_in_pool;
  logic [EXT_W-1:0]      first_ext;

  assign req.ready = (state == ST_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign load_out  = (state == ST_FINISH) && (!out_valid || rsp.ready);

  assign run_inc     = run + CNT_W'(1);
  assign first_calc  = CNT_W'(idx) + CNT_W'(1) - want;
  assign count_bad   = (req.data.cell_count == '0) ||
                       (CMP_W'(req.data.cell_count) > CMP_W'(POOL_CELLS));
  assign pos_in_pool = FCMP_W'(pos) < FCMP_W'(POOL_CELLS);
  assign first_ext   = EXT_W'(res_first);

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy_map  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_ok    <= !((req.data.opcode == OP_ALLOC) && count_bad);
            res_first <= '0;
            idx       <= '0;
            run       <= '0;
            want      <= CNT_W'(req.data.cell_count);
            pos       <= POS_W'(req.data.start_cell);
            rem       <= req.data.cell_count;
            if (req.data.opcode == OP_ALLOC) begin
              if (count_bad) begin
                state <= ST_FINISH;
              end else begin
                state <= ST_SCAN;
              end
            end else if (req.data.cell_count == '0) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_FREE;
            end
          end
        end
        ST_SCAN: begin
          if (busy_map[idx]) begin
            run <= '0;
            if (idx == IDX_W'(POOL_CELLS - 1)) begin
              res_ok <= 1'b0;
              state  <= ST_FINISH;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end else if (run_inc == want) begin
            // run found: walk back over it setting busy bits
            res_first <= IDX_W'(first_calc);
            idx       <= IDX_W'(first_calc);
            last      <= idx;
            state     <= ST_MARK;
          end else begin
            run <= run_inc;
            if (idx == IDX_W'(POOL_CELLS - 1)) begin
              res_ok <= 1'b0;
              state  <= ST_FINISH;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_MARK: begin
          busy_map[idx] <= 1'b1;
          if (idx == last) begin
            state <= ST_FINISH;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_FREE: begin
          // cells past the pool end are skipped
          if (pos_in_pool) begin
            busy_map[pos[IDX_W-1:0]] <= 1'b0;
          end
          pos <= pos + POS_W'(1);
          rem <= rem - COUNT_W'(1);
          if (rem == COUNT_W'(1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            out_valid           <= 1'b1;
            out_data.success    <= res_ok;
            out_data.first_cell <= first_ext[FIRST_W-1:0];
            out_data.pool_empty <= ~|busy_map;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb_bitmap_run_allocator.sv
`timescale 1ns / 1ps
// Testbench for bitmap_run_allocator: directed corner cases, random alloc/free traffic
// and a long response stall, all checked against a first-fit bitmap predictor.
// Depends on bra_pkg, bra_stream_if and the bitmap_run_allocator RTL.
module tb_bitmap_run_allocator;
  import bra_pkg::*;

  localparam int POOL       = POOL_CELLS_DEF;
  localparam int QUIET_MAX  = 5000;
  localparam int DRAIN_WAIT = 2 * POOL + 8;
  localparam int STALL_LEN  = 300;

  typedef struct {
    int first;
    int len;
  } run_t;

  logic clk = 1'b0;
  logic rst;

  bra_stream_if #(.T(req_t)) req_ch ();
  bra_stream_if #(.T(rsp_t)) rsp_ch ();

  bitmap_run_allocator #(.POOL_CELLS(POOL)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [POOL-1:0] busy_cells;
  rsp_t            pending_rsp[$];
  run_t            held_runs[$];
  int              error_count;
  int              send_gap_pct;
  int              recv_gap_pct;
  logic            stall_toggle;

  // First-fit allocate / range free on the predicted bitmap.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    int   run;
    int   first;
    int   c;
    bit   found;
    res = '0;
    res.success = 1'b1;
    if (r.opcode == OP_ALLOC) begin
      run = 0;
      found = 1'b0;
      if (r.cell_count != 0 && r.cell_count <= POOL) begin
        for (int i = 0; i < POOL; i++) begin
          if (found) break;
          if (busy_cells[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == r.cell_count) begin
              first = i + 1 - r.cell_count;
              for (int k = first; k <= i; k++) busy_cells[k] = 1'b1;
              res.first_cell = first[FIRST_W-1:0];
              held_runs.push_back('{first, int'(r.cell_count)});
              found = 1'b1;
            end
          end
        end
      end
      res.success = found;
    end else begin
      for (int k = 0; k < r.cell_count; k++) begin
        c = r.start_cell + k;
        if (c < POOL) busy_cells[c] = 1'b0;
      end
    end
    res.pool_empty = (busy_cells == '0);
    return res;
  endfunction

  function automatic req_t make_req(input logic [OPCODE_W-1:0] op, input int count,
                                    input int start);
    req_t r;
    r.opcode     = op;
    r.cell_count = count[COUNT_W-1:0];
    r.start_cell = start[START_W-1:0];
    return r;
  endfunction

  // Mostly allocs and frees of live runs; a few pool-wide frees and raw noise.
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    int   idx;
    roll = $urandom_range(99);
    if (roll < 45 || (roll < 85 && held_runs.size() == 0)) begin
      case ($urandom_range(9))
        0:       r = make_req(OP_ALLOC, $urandom_range(31), $urandom_range(15));
        1, 2:    r = make_req(OP_ALLOC, $urandom_range(16, 1), $urandom_range(15));
        default: r = make_req(OP_ALLOC, $urandom_range(4, 1), $urandom_range(15));
      endcase
    end else if (roll < 85) begin
      idx = $urandom_range(held_runs.size() - 1);
      r = make_req(OP_FREE, held_runs[idx].len, held_runs[idx].first);
      held_runs.delete(idx);
    end else if (roll < 88) begin
      r = make_req(OP_FREE, POOL, 0);
      held_runs.delete();
    end else begin
      r = make_req($urandom_range(1) ? OP_FREE : OP_ALLOC, $urandom_range(31),
                   $urandom_range(15));
    end
    return r;
  endfunction

  // One request beat; valid stays up if the next call follows without a gap.
  task automatic send_req(input req_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(apply_request(item));
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic test_corner_cases();
    send_req(make_req(OP_ALLOC, 0, 9));       // zero count
    send_req(make_req(OP_ALLOC, 31, 0));      // larger than pool
    send_req(make_req(OP_ALLOC, 17, 15));
    send_req(make_req(OP_FREE, 0, 0));        // zero count free on empty pool
    send_req(make_req(OP_FREE, 5, 3));        // already free
    send_req(make_req(OP_ALLOC, 16, 15));     // whole pool
    send_req(make_req(OP_ALLOC, 1, 0));       // full pool
    send_req(make_req(OP_FREE, 31, 15));      // runs past pool end
    send_req(make_req(OP_ALLOC, 1, 0));       // lands on cell 15
    send_req(make_req(OP_FREE, 16, 0));
    send_req(make_req(OP_ALLOC, 1, 7));
    send_req(make_req(OP_ALLOC, 3, 0));
    send_req(make_req(OP_ALLOC, 2, 10));
    send_req(make_req(OP_FREE, 3, 1));        // hole of three
    send_req(make_req(OP_ALLOC, 4, 0));       // must skip the hole
    send_req(make_req(OP_ALLOC, 3, 0));       // fills the hole
    send_req(make_req(OP_ALLOC, 7, 0));
    send_req(make_req(OP_ALLOC, 1, 0));
    send_req(make_req(OP_FREE, 15, 1));
    send_req(make_req(OP_FREE, 1, 0));
    send_req(make_req(OP_ALLOC, 16, 0));
    send_req(make_req(OP_FREE, 16, 0));
    held_runs.delete();
    drain();
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int i = 0; i < n_items; i++) send_req(pick_request());
    drain();
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    @(negedge clk);
    stall_toggle <= ~stall_toggle;
    for (int i = 0; i < 40; i++) send_req(pick_request());
    drain();
  endtask

  // Response side: ready pattern, with a long hold-off on request.
  logic stall_seen;
  int   stall_left;
  always @(negedge clk) begin
    if (stall_toggle != stall_seen) begin
      stall_seen = stall_toggle;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, rsp_ch.data);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.data.success !== want.success) begin
          $display("%0t: success expected %0b got %0b", $time, want.success,
                   rsp_ch.data.success);
          error_count++;
        end
        if (rsp_ch.data.first_cell !== want.first_cell) begin
          $display("%0t: first_cell expected %0d got %0d", $time, want.first_cell,
                   rsp_ch.data.first_cell);
          error_count++;
        end
        if (rsp_ch.data.pool_empty !== want.pool_empty) begin
          $display("%0t: pool_empty expected %0b got %0b", $time, want.pool_empty,
                   rsp_ch.data.pool_empty);
          error_count++;
        end
      end
    end
  end

  int quiet_cycles;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("bitmap_run_allocator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    busy_cells    = '0;
    error_count   = 0;
    send_gap_pct  = 23;
    recv_gap_pct  = 79;
    stall_toggle  = 1'b0;
    stall_seen    = 1'b0;
    stall_left    = 0;
    quiet_cycles  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_random_traffic(640, 23, 79);
    test_random_traffic(640, 79, 23);
    test_random_traffic(610, 0, 0);
    test_backpressure();

    if (error_count == 0) begin
      $display("bitmap_run_allocator regression: pass");
    end else begin
      $display("bitmap_run_allocator regression: fail");
    end
    $finish;
  end

endmodule
